/* hw/rtl/single_wire_humidity_sensor_reader_unit_macros.svh */
// Assertion macros for the single-wire humidity sensor reader.
// Used by the top level only; the checks vanish when SYNTHESIS is defined.
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_UNIT_MACROS_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SWH_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("single-wire reader check failed");
`define SWH_ASSERT_NEXT(label, trig, resp) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (resp)) \
        else $error("single-wire reader sequence check failed");
`else
`define SWH_ASSERT(label, prop)
`define SWH_ASSERT_NEXT(label, trig, resp)
`endif
`endif

/* hw/rtl/swh_pkg.sv */
// Shared types and constants for the single-wire humidity sensor reader.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package swh_pkg;

    localparam int FRAME_BITS_DEF = 40;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_START_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [CFG_W-1:0] START_TICKS_RST   = 16'd1280;
    localparam logic [CFG_W-1:0] BIT_THRESHOLD_RST = 16'd800;
    localparam logic [CFG_W-1:0] TIMEOUT_TICKS_RST = 16'd65535;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd2;
    localparam logic [1:0] STATUS_UNUSED   = 2'd3;

    localparam int DECODE_BITS = 40;

    typedef struct packed {
        logic start_req;
        logic line_level;
    } swh_item_t;

    typedef struct packed {
        logic               pull_low;
        logic               busy_res;
        logic               done_res;
        logic [1:0]         status;
        logic [15:0]        humidity;
        logic signed [15:0] temperature;
    } swh_result_t;

    typedef struct packed {
        logic      en;
        swh_item_t item;
    } swh_step_t;

    typedef struct packed {
        logic               csum_ok;
        logic [15:0]        humidity;
        logic signed [15:0] temperature;
    } swh_decode_t;

endpackage

/* hw/rtl/swh_frame_decode.sv */
// Checksum test and field decode of a finished 40-bit sensor frame.
// Depends on swh_pkg.
`timescale 1ns / 1ps

module swh_frame_decode (
    input  logic [swh_pkg::DECODE_BITS-1:0] frame,
    output swh_pkg::swh_decode_t            decoded
);

    logic [7:0]  sum;
    logic [15:0] raw_temp;
    logic [15:0] mag;

    assign sum      = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
    assign raw_temp = frame[23:8];
    assign mag      = {1'b0, raw_temp[14:0]};

    assign decoded.csum_ok     = (sum == frame[7:0]);
    assign decoded.humidity    = frame[39:24];
    assign decoded.temperature = $signed(raw_temp[15] ? (16'd0 - mag) : mag);

endmodule

/* hw/rtl/swh_core.sv */
// Reader state, configuration registers and the per-tick update logic.
// Depends on swh_pkg and swh_frame_decode.
`timescale 1ns / 1ps

module swh_core #(
    parameter int FRAME_BITS = swh_pkg::FRAME_BITS_DEF,
    parameter int COUNT_BITS = swh_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [swh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swh_pkg::CFG_W-1:0]     cfg_data,
    input  swh_pkg::swh_step_t            step,
    output swh_pkg::swh_result_t          result_next
);

    localparam int EDGE_W = $clog2(FRAME_BITS + 2);
    localparam int CMP_W  = (COUNT_BITS > swh_pkg::CFG_W) ? COUNT_BITS : swh_pkg::CFG_W;
    localparam int EXT_W  = FRAME_BITS + swh_pkg::DECODE_BITS;
    localparam logic [EDGE_W-1:0]     EDGES_INIT  = EDGE_W'(FRAME_BITS + 1);
    localparam logic [EDGE_W-1:0]     FRAME_LIMIT = EDGE_W'(FRAME_BITS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_START   = 2'd1,
        PH_CAPTURE = 2'd2
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [COUNT_BITS-1:0]    tick_reg, tick_next;
    logic                     prev_level_reg, prev_level_next;
    logic                     expect_rise_reg, expect_rise_next;
    logic [EDGE_W-1:0]        edges_reg, edges_next;
    logic [FRAME_BITS-1:0]    frame_reg, frame_next;
    logic [1:0]               status_reg, status_next;
    logic [15:0]              humidity_reg, humidity_next;
    logic signed [15:0]       temp_reg, temp_next;
    logic [swh_pkg::CFG_W-1:0] start_ticks_reg, bit_threshold_reg, timeout_ticks_reg;

    logic                     bit_val;
    logic [FRAME_BITS-1:0]    frame_shift;
    logic [EXT_W-1:0]         frame_ext;
    logic [COUNT_BITS-1:0]    tick_inc;
    logic                     rising, falling, hit, done;
    swh_pkg::swh_decode_t     decoded;

    assign bit_val     = CMP_W'(tick_reg) > CMP_W'(bit_threshold_reg);
    assign frame_shift = {frame_reg[FRAME_BITS-2:0], bit_val};
    assign frame_ext   = EXT_W'(frame_shift);
    assign tick_inc    = (tick_reg != COUNT_MAX) ? tick_reg + 1'b1 : tick_reg;
    assign rising      = !prev_level_reg && step.item.line_level;
    assign falling     = prev_level_reg && !step.item.line_level;
    assign hit         = expect_rise_reg ? rising : falling;

    swh_frame_decode u_decode (
        .frame   (frame_ext[swh_pkg::DECODE_BITS-1:0]),
        .decoded (decoded)
    );

    always_comb
    begin
        phase_next       = phase_reg;
        tick_next        = tick_reg;
        prev_level_next  = prev_level_reg;
        expect_rise_next = expect_rise_reg;
        edges_next       = edges_reg;
        frame_next       = frame_reg;
        status_next      = status_reg;
        humidity_next    = humidity_reg;
        temp_next        = temp_reg;
        done             = 1'b0;
        if (step.en)
        begin
            prev_level_next = step.item.line_level;
            if (step.item.start_req)
            begin
                phase_next       = PH_START;
                tick_next        = '0;
                edges_next       = EDGES_INIT;
                frame_next       = '0;
                expect_rise_next = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        tick_next = tick_inc;
                        if (CMP_W'(tick_inc) >= CMP_W'(start_ticks_reg) || tick_inc == COUNT_MAX)
                        begin
                            phase_next       = PH_CAPTURE;
                            tick_next        = '0;
                            expect_rise_next = 1'b0;
                        end
                    end
                    PH_CAPTURE:
                    begin
                        if (hit)
                        begin
                            tick_next = '0;
                            if (expect_rise_reg)
                            begin
                                expect_rise_next = 1'b0;
                            end
                            else
                            begin
                                expect_rise_next = 1'b1;
                                if (edges_reg < FRAME_LIMIT)
                                begin
                                    frame_next = frame_shift;
                                end
                                if (edges_reg == '0)
                                begin
                                    phase_next = PH_IDLE;
                                    done       = 1'b1;
                                    if (decoded.csum_ok)
                                    begin
                                        status_next   = swh_pkg::STATUS_OK;
                                        humidity_next = decoded.humidity;
                                        temp_next     = decoded.temperature;
                                    end
                                    else
                                    begin
                                        status_next = swh_pkg::STATUS_CHECKSUM;
                                    end
                                end
                                else
                                begin
                                    edges_next = edges_reg - 1'b1;
                                end
                            end
                        end
                        else if (CMP_W'(tick_reg) >= CMP_W'(timeout_ticks_reg) ||
                                 tick_reg == COUNT_MAX)
                        begin
                            phase_next  = PH_IDLE;
                            done        = 1'b1;
                            status_next = swh_pkg::STATUS_TIMEOUT;
                        end
                        else
                        begin
                            tick_next = tick_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        result_next.pull_low    = (phase_next == PH_START);
        result_next.busy_res    = (phase_next != PH_IDLE);
        result_next.done_res    = done;
        result_next.status      = status_next;
        result_next.humidity    = humidity_next;
        result_next.temperature = temp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            tick_reg          <= '0;
            prev_level_reg    <= 1'b1;
            expect_rise_reg   <= 1'b0;
            edges_reg         <= '0;
            frame_reg         <= '0;
            status_reg        <= swh_pkg::STATUS_OK;
            humidity_reg      <= '0;
            temp_reg          <= '0;
            start_ticks_reg   <= swh_pkg::START_TICKS_RST;
            bit_threshold_reg <= swh_pkg::BIT_THRESHOLD_RST;
            timeout_ticks_reg <= swh_pkg::TIMEOUT_TICKS_RST;
        end
        else
        begin
            phase_reg       <= phase_next;
            tick_reg        <= tick_next;
            prev_level_reg  <= prev_level_next;
            expect_rise_reg <= expect_rise_next;
            edges_reg       <= edges_next;
            frame_reg       <= frame_next;
            status_reg      <= status_next;
            humidity_reg    <= humidity_next;
            temp_reg        <= temp_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    swh_pkg::REG_START_TICKS:   start_ticks_reg   <= cfg_data;
                    swh_pkg::REG_BIT_THRESHOLD: bit_threshold_reg <= cfg_data;
                    swh_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                    default:                    ;
                endcase
            end
        end
    end

endmodule

/* hw/rtl/single_wire_humidity_sensor_reader_unit.sv */
// Top level of the single-wire humidity sensor reader: input and result registers.
// Depends on swh_pkg, swh_core and the assertion macro header.
//
// Usage: each item beat on the item channel is one sampled tick of the sensor data
// line (line_level) plus a start request. A start request drives pull_low for
// start_ticks beats, then the block times the line and assembles the 40-bit frame.
// Every item beat yields exactly one result beat carrying pull_low, busy, a
// one-beat done flag, status and the humidity and temperature of the last good read.
// An item sits in the input register until the result register is empty or being read;
// then its result is registered there and offered, so a stalled receiver delays it.
// Throughput: one item per cycle while the receiver does not stall; the state update for
// one tick is a single pass of logic between the input and result registers.
// When the receiver stalls the result register holds, the input register still takes
// one more beat, and item_ready drops only while both are full.
// Reset empties both registers, the reader returns to idle with status ok and zero
// readings, and the three configuration registers take their default values.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect at once; the user must
// make them only while the block is idle, as the block does not enforce it.
`timescale 1ns / 1ps
`include "single_wire_humidity_sensor_reader_unit_macros.svh"

module single_wire_humidity_sensor_reader_unit #(
    parameter int FRAME_BITS = swh_pkg::FRAME_BITS_DEF,
    parameter int COUNT_BITS = swh_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  swh_pkg::swh_item_t            item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output swh_pkg::swh_result_t          result,
    input  logic                          cfg_we,
    input  logic [swh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swh_pkg::CFG_W-1:0]     cfg_data
);

    logic                 in_vld_reg;
    swh_pkg::swh_item_t   in_item_reg;
    logic                 out_vld_reg;
    swh_pkg::swh_result_t out_reg;
    logic                 advance;
    swh_pkg::swh_step_t   step;
    swh_pkg::swh_result_t result_next;

    assign advance      = in_vld_reg && (!out_vld_reg || result_ready);
    assign item_ready   = !in_vld_reg || advance;
    assign step.en      = advance;
    assign step.item    = in_item_reg;
    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    swh_core #(
        .FRAME_BITS (FRAME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step        (step),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_item_reg <= item;
        end
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    `SWH_ASSERT(a_pull_implies_busy, result_valid |-> (!result.pull_low || result.busy_res))
    `SWH_ASSERT(a_done_ends_busy, (result_valid && result.done_res) |-> !result.busy_res)
    `SWH_ASSERT(a_status_code, result_valid |-> (result.status != swh_pkg::STATUS_UNUSED))
    `SWH_ASSERT(a_ready_on_stall, !item_ready |-> (in_vld_reg && out_vld_reg && !result_ready))
    `SWH_ASSERT_NEXT(a_stall_keeps_item, in_vld_reg && !advance, in_vld_reg)

endmodule

/* dv/swh_check_pkg.sv */
// Result predictor and checker for the single-wire humidity sensor reader testbench.
// Depends on swh_pkg for the beat types, register indexes and status codes.
`timescale 1ns / 1ps

package swh_check_pkg;
    import swh_pkg::*;

    localparam int          FRAME_LEN    = FRAME_BITS_DEF;
    localparam logic [15:0] TICK_CEILING = 16'hffff;
    localparam int          SHOWN_ERRORS = 40;

    typedef enum logic [1:0] {
        RD_IDLE,
        RD_START,
        RD_CAPTURE
    } read_phase_e;

    class reading_board;
        logic [15:0]          start_ticks   = START_TICKS_RST;
        logic [15:0]          bit_threshold = BIT_THRESHOLD_RST;
        logic [15:0]          timeout_ticks = TIMEOUT_TICKS_RST;

        read_phase_e          phase         = RD_IDLE;
        logic [15:0]          ticks         = '0;
        logic                 prev_level    = 1'b1;
        logic                 expect_rising = 1'b0;
        logic [5:0]           edges_left    = '0;
        logic [FRAME_LEN-1:0] frame         = '0;
        logic [1:0]           last_status   = STATUS_OK;
        logic [15:0]          humidity      = '0;
        logic signed [15:0]   temperature   = '0;

        swh_result_t          due_readings[$];
        int                   errors        = 0;
        int                   checked       = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [15:0] value);
            case (index)
                REG_START_TICKS:   start_ticks = value;
                REG_BIT_THRESHOLD: bit_threshold = value;
                REG_TIMEOUT_TICKS: timeout_ticks = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return due_readings.size();
        endfunction

        function bit busy();
            return phase != RD_IDLE;
        endfunction

        function void decode_frame();
            logic [7:0]  sum;
            logic [15:0] raw;
            logic [15:0] mag;
            sum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
            if (sum != frame[7:0]) begin
                last_status = STATUS_CHECKSUM;
                return;
            end
            last_status = STATUS_OK;
            humidity = frame[39:24];
            raw = frame[23:8];
            mag = {1'b0, raw[14:0]};
            temperature = raw[15] ? -mag : mag;
        endfunction

        // Advances the reader by one tick and queues the reading it must show.
        function void take_tick(swh_item_t tick);
            swh_result_t want;
            logic        hit;
            logic [15:0] width;
            logic        done;
            done = 1'b0;
            if (tick.start_req) begin
                phase = RD_START;
                ticks = '0;
                edges_left = 6'(FRAME_LEN + 1);
                frame = '0;
                expect_rising = 1'b0;
            end else if (phase == RD_START) begin
                if (ticks != TICK_CEILING)
                    ticks++;
                if (ticks >= start_ticks || ticks == TICK_CEILING) begin
                    phase = RD_CAPTURE;
                    ticks = '0;
                    expect_rising = 1'b0;
                end
            end else if (phase == RD_CAPTURE) begin
                hit = expect_rising ? (!prev_level && tick.line_level)
                                    : (prev_level && !tick.line_level);
                if (hit) begin
                    width = ticks;
                    ticks = '0;
                    if (expect_rising) begin
                        expect_rising = 1'b0;
                    end else begin
                        expect_rising = 1'b1;
                        if (edges_left < FRAME_LEN)
                            frame = {frame[FRAME_LEN-2:0], width > bit_threshold};
                        if (edges_left == 0) begin
                            phase = RD_IDLE;
                            done = 1'b1;
                            decode_frame();
                        end else begin
                            edges_left--;
                        end
                    end
                end else if (ticks >= timeout_ticks || ticks == TICK_CEILING) begin
                    phase = RD_IDLE;
                    done = 1'b1;
                    last_status = STATUS_TIMEOUT;
                end else begin
                    ticks++;
                end
            end
            prev_level = tick.line_level;

            want.pull_low = (phase == RD_START);
            want.busy_res = (phase != RD_IDLE);
            want.done_res = done;
            want.status = last_status;
            want.humidity = humidity;
            want.temperature = temperature;
            due_readings.push_back(want);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= SHOWN_ERRORS)
                $display("%0t ns: reading %0d: %s", $time, checked, msg);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        task check_reading(swh_result_t got);
            swh_result_t want;
            if (due_readings.size() == 0) begin
                report("result beat with no reading expected");
                return;
            end
            want = due_readings.pop_front();
            compare_field("pull_low", got.pull_low, want.pull_low);
            compare_field("busy_res", got.busy_res, want.busy_res);
            compare_field("done_res", got.done_res, want.done_res);
            compare_field("status", got.status, want.status);
            compare_field("humidity", got.humidity, want.humidity);
            compare_field("temperature", got.temperature, want.temperature);
            checked++;
        endtask
    endclass

endpackage

/* dv/testbench.sv */
// Top-level testbench for the single-wire humidity sensor reader.
// Drives sensor line ticks and register writes; depends on swh_pkg and swh_check_pkg.
`timescale 1ns / 1ps

module testbench;
    import swh_pkg::*;
    import swh_check_pkg::*;

    localparam int CYCLE_LIMIT = 100_000;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_ready;
    swh_item_t            item         = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    swh_result_t          result;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;

    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           cycles        = 0;
    int           ticks_sent    = 0;
    reading_board board;

    single_wire_humidity_sensor_reader_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                board.check_reading(result);
            result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic req, input logic level);
        swh_item_t beat;
        beat.start_req = req;
        beat.line_level = level;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= beat;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        board.take_tick(beat);
        ticks_sent++;
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Holds the line high until any read under way has ended.
    task automatic settle_reader();
        while (board.busy())
            send_item(1'b0, 1'b1);
    endtask

    task automatic load_config(input logic [15:0] start_val, input logic [15:0] thr_val,
                               input logic [15:0] timeout_val);
        logic [CFG_IDX_W-1:0] regs [3];
        logic [15:0]          vals [3];
        regs = '{REG_START_TICKS, REG_BIT_THRESHOLD, REG_TIMEOUT_TICKS};
        vals = '{start_val, thr_val, timeout_val};
        settle_reader();
        drain_results();
        for (int i = 0; i < 3; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(posedge clk);
            board.set_reg(regs[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [39:0] make_frame(logic [15:0] hum, logic [15:0] traw,
                                               logic corrupt);
        logic [7:0] sum;
        sum = hum[15:8] + hum[7:0] + traw[15:8] + traw[7:0];
        if (corrupt)
            sum = sum + 8'($urandom_range(1, 255));
        return {hum, traw, sum};
    endfunction

    // Plays the sensor side of one read, stopping after the given number of falling edges.
    task automatic send_read(input logic [39:0] bits, input int falls);
        int thr;
        int span;
        thr = board.bit_threshold;
        send_item(1'b1, 1'b0);
        repeat (int'(board.start_ticks) + $urandom_range(0, 1)) send_item(1'b0, 1'b0);
        for (int k = 1; k <= falls; k++)
        begin
            if (k < 3)
                span = $urandom_range(1, 3);
            else if (bits[42 - k])
                span = thr + 2 + $urandom_range(0, 1);
            else
                span = $urandom_range(1, (thr + 1 < 4) ? thr + 1 : 4);
            repeat (span) send_item(1'b0, 1'b1);
            repeat ($urandom_range(1, 2)) send_item(1'b0, 1'b0);
        end
    endtask

    task automatic random_reads(input int quota);
        int          stop_at;
        int          pick;
        logic [15:0] hum;
        logic [15:0] traw;
        stop_at = ticks_sent + quota;
        while (ticks_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            hum = 16'($urandom);
            traw = 16'($urandom);
            if (pick < 70)
                send_read(make_frame(hum, traw, 1'b0), 42);
            else if (pick < 80)
                send_read(make_frame(hum, traw, 1'b1), 42);
            else if (pick < 90)
            begin
                send_read(make_frame(hum, traw, 1'b0), $urandom_range(0, 41));
                if ($urandom_range(0, 1) == 0)
                    settle_reader();
            end
            else
            begin
                repeat ($urandom_range(1, 20))
                    send_item($urandom_range(0, 19) == 0, 1'($urandom_range(0, 1)));
            end
            repeat ($urandom_range(0, 3)) send_item(1'b0, 1'b1);
            if ($urandom_range(0, 19) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        logic [15:0] thr;
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 47;
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);

        load_config(16'd1, 16'd1, 16'd8);
        send_read(make_frame(16'hffff, 16'h7fff, 1'b0), 42);
        send_read(make_frame(16'h0215, 16'h8000, 1'b0), 42);
        send_read(make_frame(16'h8001, 16'hffff, 1'b0), 42);
        send_read(make_frame(16'h1234, 16'h80f5, 1'b1), 42);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b0);
        send_read(make_frame(16'h0321, 16'h0111, 1'b0), 20);
        settle_reader();

        load_config(16'd1, 16'd1, 16'd6);
        random_reads(80);

        send_idle_pct = 47;
        recv_idle_pct = 32;
        load_config(16'd5, 16'd4, 16'd1);
        send_read(make_frame(16'h0100, 16'h0000, 1'b0), 4);
        random_reads(50);
        load_config(16'd3, 16'd3, 16'd30);
        random_reads(60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_config(16'd2, 16'd2, 16'd9);
        send_read(40'h0, 41);
        settle_reader();
        thr = 16'($urandom_range(1, 5));
        load_config(16'($urandom_range(1, 8)), thr, thr + 16'($urandom_range(3, 35)));
        random_reads(60);

        drain_results();
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/swh_pkg.sv
hw/rtl/swh_frame_decode.sv
hw/rtl/swh_core.sv
hw/rtl/single_wire_humidity_sensor_reader_unit.sv
dv/swh_check_pkg.sv
dv/testbench.sv
